/* design/mvc_pkg.sv */
// Shared package for the multi-voice chorus: widths, register indexes,
// the controller/datapath command and status words, and the sine table.
// No dependencies.
package mvc_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int DELAY_DEPTH  = 2048;
    localparam int DELAY_AW     = $clog2(DELAY_DEPTH);
    localparam int MAX_VOICES   = 8;
    localparam int VOICE_W      = $clog2(MAX_VOICES);
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);
    localparam int SINE_W       = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASE_DELAY  = 3'd0;
    localparam logic [2:0] CFG_MOD_DEPTH   = 3'd1;
    localparam logic [2:0] CFG_RATE_STEP   = 3'd2;
    localparam logic [2:0] CFG_WET_GAIN    = 3'd3;
    localparam logic [2:0] CFG_VOICE_COUNT = 3'd4;
    localparam int CFG_DATA_W = 23;

    // Delay clamp, Q11.8
    localparam int DLY_MIN = 256;
    localparam int DLY_MAX = (DELAY_DEPTH - 4) * 256;

    // Lagrange weights are scaled by 6 * 2^24 = 3 * 2^25
    localparam int LAG_DEN  = 100663296;
    localparam int LAG_HALF = LAG_DEN / 2;
    // floor(u / 3) for u below 2^28: (u * RECIP3) >> 30
    localparam logic [28:0] RECIP3   = 29'd357913942;
    localparam int          DIV3_OFS = 3 * (1 << 26);

    // Small-divisor long division: 8 quotient bits per cycle
    localparam int DIV_W     = 40;
    localparam int DVS_W     = 7;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;

    localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       wr_in;
        logic       sin;
        logic       mul;
        logic       pos;
        logic       rd;
        logic [1:0] tap;
        logic       f2;
        logic       f3;
        logic       wgt;
        logic       mac;
        logic       acc_clr;
        logic       acc_add;
        logic       rnd1;
        logic       rnd2;
        logic       rnd3;
        logic       adv;
        logic       fin1;
        logic       fin2;
        logic       fin3;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic last_voice;
        logic div_busy;
        logic out_free;
    } t_status;

    typedef logic signed [SINE_W-1:0] t_sine_tab [SINE_ENTRIES];

    // Q1.15 quarter-folded Taylor sine, angle in Q30
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab         tab;
        longint unsigned   theta;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            s;
        logic              neg;
        longint unsigned   pi_q30;
        longint unsigned   half_pi_q30;
        longint unsigned   two_pi_q30;
        pi_q30      = 64'd3373259426;
        half_pi_q30 = 64'd1686629713;
        two_pi_q30  = 64'd6746518852;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            theta = (two_pi_q30 * longint'(i)) / SINE_ENTRIES;
            neg = 1'b0;
            if (theta >= pi_q30) begin
                theta = theta - pi_q30;
                neg = 1'b1;
            end
            if (theta > half_pi_q30) begin
                theta = pi_q30 - theta;
            end
            x = theta;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            // odd powers x^3 .. x^13, signs alternate
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            s = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (s > 32767) begin
                s = 32767;
            end
            tab[i] = SINE_W'(neg ? -s : s);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

    // Start phases spread evenly over three voices
    function automatic logic [31:0] f_phase_init(int i);
        logic [63:0] p;
        p = (64'(i) << 32) / 3;
        return p[31:0];
    endfunction

endpackage

/* design/mvc_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module mvc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mvc_div.sv */
// Unsigned long division by a small divisor, eight quotient bits a cycle.
// Depends on mvc_pkg.
module mvc_div
    import mvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quot
);

    logic                 r_busy;
    logic [2:0]           r_cnt;
    logic [DIV_W-1:0]     r_work;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     n_work;
    logic [DVS_W-1:0]     n_rem;

    always_comb begin
        logic [DVS_W:0] rem8;
        n_rem  = r_rem;
        n_work = r_work;
        for (int j = 0; j < DIV_BITS; j++) begin
            rem8   = {n_rem, n_work[DIV_W-1]};
            n_work = {n_work[DIV_W-2:0], 1'b0};
            if (rem8 >= {1'b0, r_dvs}) begin
                rem8      = rem8 - {1'b0, r_dvs};
                n_work[0] = 1'b1;
            end
            n_rem = rem8[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_work;

endmodule

/* design/mvc_ctrl.sv */
// Chorus sequencer: clearing pass, input accept, per-voice steps, final mix.
// Depends on mvc_pkg.
module mvc_ctrl
    import mvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [23:0] {
        S_CLR  = 24'h000001,
        S_IDLE = 24'h000002,
        S_WR   = 24'h000004,
        S_SIN  = 24'h000008,
        S_MUL  = 24'h000010,
        S_POS  = 24'h000020,
        S_RD0  = 24'h000040,
        S_RD1  = 24'h000080,
        S_RD2  = 24'h000100,
        S_RD3  = 24'h000200,
        S_MAC0 = 24'h000400,
        S_MAC1 = 24'h000800,
        S_MAC2 = 24'h001000,
        S_MAC3 = 24'h002000,
        S_ACC  = 24'h004000,
        S_RND1 = 24'h008000,
        S_RND2 = 24'h010000,
        S_RND3 = 24'h020000,
        S_ADV  = 24'h040000,
        S_FIN1 = 24'h080000,
        S_FIN2 = 24'h100000,
        S_FIN3 = 24'h200000,
        S_OUT  = 24'h400000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr_in = 1'b1;
                n_state     = S_SIN;
            end
            S_SIN: begin
                o_cmd.sin = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = 2'd0;
                o_cmd.f2  = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = 2'd1;
                o_cmd.f3  = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = 2'd2;
                o_cmd.wgt = 1'b1;
                n_state   = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = 2'd3;
                n_state   = S_MAC0;
            end
            S_MAC0: begin
                o_cmd.mac     = 1'b1;
                o_cmd.tap     = 2'd0;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_MAC1;
            end
            S_MAC1: begin
                o_cmd.mac     = 1'b1;
                o_cmd.tap     = 2'd1;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MAC2;
            end
            S_MAC2: begin
                o_cmd.mac     = 1'b1;
                o_cmd.tap     = 2'd2;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MAC3;
            end
            S_MAC3: begin
                o_cmd.mac     = 1'b1;
                o_cmd.tap     = 2'd3;
                o_cmd.acc_add = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_RND1;
            end
            S_RND1: begin
                o_cmd.rnd1 = 1'b1;
                n_state    = S_RND2;
            end
            S_RND2: begin
                o_cmd.rnd2 = 1'b1;
                n_state    = S_RND3;
            end
            S_RND3: begin
                o_cmd.rnd3 = 1'b1;
                n_state    = S_ADV;
            end
            S_ADV: begin
                // hold until the voice step quotient is ready
                if (!i_st.div_busy) begin
                    o_cmd.adv = 1'b1;
                    n_state   = i_st.last_voice ? S_FIN1 : S_SIN;
                end
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = S_FIN3;
            end
            S_FIN3: begin
                o_cmd.fin3 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_st.div_busy && i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* design/mvc_dp.sv */
// Chorus datapath: registers, delay line, LFO phases, interpolation and mix.
// Depends on mvc_pkg, mvc_ram and mvc_div.
module mvc_dp
    import mvc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_st,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [2:0]                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    logic [18:0] r_base;
    logic [18:0] r_depth;
    logic [22:0] r_rate;
    logic [16:0] r_wet;
    logic [3:0]  r_vcnt;

    logic [3:0]         c_n;
    logic [VOICE_W-1:0] c_nm1;
    logic [16:0]        c_w;
    logic [16:0]        c_wdry;

    // control state
    logic [DELAY_AW-1:0] r_wp;
    logic [DELAY_AW-1:0] r_clr;
    logic [VOICE_W-1:0]  r_v;
    logic [31:0]         r_phase [MAX_VOICES];
    logic                r_cap_en;
    logic [1:0]          r_cap_idx;
    logic                r_ovalid;

    // payload
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SINE_W-1:0]   r_sine;
    logic [29:0]                r_stepnum;
    logic signed [35:0]         r_mprod;
    logic [DELAY_AW-1:0]        r_k;
    logic [7:0]                 r_f;
    logic [15:0]                r_f2;
    logic [23:0]                r_f3;
    logic signed [29:0]         r_wgt [4];
    logic signed [SAMPLE_W-1:0] r_tap [4];
    logic signed [53:0]         r_prod;
    logic signed [53:0]         r_acc;
    logic [27:0]                r_u;
    logic [56:0]                r_qm;
    logic signed [28:0]         r_wsum;
    logic signed [41:0]         r_p1;
    logic signed [46:0]         r_p1n;
    logic signed [46:0]         r_p2;
    logic signed [SAMPLE_W-1:0] r_out;

    // combinational
    logic [6:0]                 c_coef;
    logic [DVS_W-1:0]           c_sdiv;
    logic signed [20:0]         c_dofs;
    logic signed [21:0]         c_d;
    logic [18:0]                c_dcl;
    logic [18:0]                c_diff;
    logic [DELAY_AW-1:0]        c_taddr;
    logic signed [29:0]         c_sf;
    logic signed [29:0]         c_sf2;
    logic signed [29:0]         c_sf3;
    logic signed [53:0]         c_acch;
    logic signed [28:0]         c_t;
    logic signed [28:0]         c_voice;
    logic [31:0]                c_step;
    logic signed [47:0]         c_fsum;
    logic signed [31:0]         c_t2;
    logic signed [DIV_W-1:0]    c_fin_div;
    logic signed [DIV_W:0]      c_y;
    logic signed [SAMPLE_W-1:0] c_sat;

    logic                       ram_we;
    logic [DELAY_AW-1:0]        ram_addr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [SAMPLE_W-1:0]        ram_rdata;

    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic                       div_busy;
    logic [DIV_W-1:0]           div_quot;

    always_comb begin
        if (r_vcnt == 4'd0) begin
            c_n = 4'd1;
        end else if (r_vcnt > 4'(MAX_VOICES)) begin
            c_n = 4'(MAX_VOICES);
        end else begin
            c_n = r_vcnt;
        end
        c_nm1  = VOICE_W'(c_n - 4'd1);
        c_w    = (r_wet > 17'h10000) ? 17'h10000 : r_wet;
        c_wdry = 17'h10000 - c_w;
    end

    // voice rate: rate * (9(n-1) + 2v) / (10(n-1))
    assign c_coef = ({4'b0, c_nm1} << 3) + {4'b0, c_nm1} + {3'b0, r_v, 1'b0};
    assign c_sdiv = ({4'b0, c_nm1} << 3) + ({4'b0, c_nm1} << 1);
    assign c_step = (c_n == 4'd1) ? {9'b0, r_rate} : div_quot[31:0];

    // read position: delay clamp, then wrap modulo the line length
    always_comb begin
        c_dofs = r_mprod[35:15];
        c_d    = $signed({3'b0, r_base}) + $signed({c_dofs[20], c_dofs});
        if (c_d < $signed(22'(DLY_MIN))) begin
            c_dcl = 19'(DLY_MIN);
        end else if (c_d > $signed(22'(DLY_MAX))) begin
            c_dcl = 19'(DLY_MAX);
        end else begin
            c_dcl = c_d[18:0];
        end
        c_diff = {r_wp, 8'h00} - c_dcl;
    end

    assign c_taddr = r_k + DELAY_AW'(i_cmd.tap) - DELAY_AW'(1);

    assign c_sf  = $signed({22'b0, r_f});
    assign c_sf2 = $signed({14'b0, r_f2});
    assign c_sf3 = $signed({6'b0, r_f3});

    // round half up and divide by 3 * 2^25
    assign c_acch  = r_acc + 54'(LAG_HALF);
    assign c_t     = c_acch[53:25];
    assign c_voice = $signed({2'b0, r_qm[56:30]}) - $signed(29'(1 << 26));

    // final mix: ((65536-w)*x*n + w*S + 32768n) >> 16, then floor divide by n
    assign c_fsum    = 48'(r_p1n) + 48'(r_p2) + $signed({29'b0, c_n, 15'b0});
    assign c_t2      = c_fsum[47:16];
    assign c_fin_div = $signed({{8{c_t2[31]}}, c_t2}) + $signed({5'b0, c_n, 31'b0});
    assign c_y       = $signed({1'b0, div_quot}) - $signed({9'b0, 1'b1, 31'b0});

    always_comb begin
        if (c_y > 41'(SMAX)) begin
            c_sat = SMAX;
        end else if (c_y < 41'(SMIN)) begin
            c_sat = SMIN;
        end else begin
            c_sat = c_y[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        ram_we    = i_cmd.clr | i_cmd.wr_in;
        ram_wdata = i_cmd.clr ? '0 : r_x;
        if (i_cmd.clr) begin
            ram_addr = r_clr;
        end else if (i_cmd.wr_in) begin
            ram_addr = r_wp;
        end else begin
            ram_addr = c_taddr;
        end
    end

    assign div_start    = i_cmd.mul | i_cmd.fin3;
    assign div_dividend = i_cmd.mul ? {10'b0, r_stepnum} : c_fin_div;
    assign div_divisor  = i_cmd.mul ? c_sdiv : {3'b0, c_n};

    mvc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    mvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= 19'd245760;
            r_depth   <= 19'd24576;
            r_rate    <= 23'd89478;
            r_wet     <= 17'd32768;
            r_vcnt    <= 4'd3;
            r_wp      <= DELAY_AW'(1);
            r_clr     <= '0;
            r_v       <= '0;
            r_cap_en  <= 1'b0;
            r_cap_idx <= '0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < MAX_VOICES; i++) begin
                r_phase[i] <= f_phase_init(i);
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE_DELAY:  r_base  <= i_cfg_data[18:0];
                    CFG_MOD_DEPTH:   r_depth <= i_cfg_data[18:0];
                    CFG_RATE_STEP:   r_rate  <= i_cfg_data[22:0];
                    CFG_WET_GAIN:    r_wet   <= i_cfg_data[16:0];
                    CFG_VOICE_COUNT: r_vcnt  <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + DELAY_AW'(1);
            end
            if (i_cmd.load) begin
                r_v <= '0;
            end
            if (i_cmd.adv) begin
                r_phase[r_v] <= r_phase[r_v] + c_step;
                r_v          <= r_v + VOICE_W'(1);
            end
            r_cap_en  <= i_cmd.rd;
            r_cap_idx <= i_cmd.tap;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_wp     <= r_wp + DELAY_AW'(1);
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample_in;
            r_wsum <= '0;
        end
        if (i_cmd.sin) begin
            r_sine    <= SINE_TAB[r_phase[r_v][31 -: SINE_AW]];
            r_stepnum <= r_rate * c_coef;
        end
        if (i_cmd.mul) begin
            r_mprod <= $signed({1'b0, r_depth}) * r_sine;
        end
        if (i_cmd.pos) begin
            r_k <= c_diff[18:8];
            r_f <= c_diff[7:0];
        end
        if (i_cmd.f2) begin
            r_f2 <= r_f * r_f;
        end
        if (i_cmd.f3) begin
            r_f3 <= r_f2 * r_f;
        end
        if (i_cmd.wgt) begin
            r_wgt[0] <= -c_sf3 + 30'sd768 * c_sf2 - 30'sd131072 * c_sf;
            r_wgt[1] <= 30'sd3 * c_sf3 - 30'sd1536 * c_sf2 - 30'sd196608 * c_sf
                        + 30'(LAG_DEN);
            r_wgt[2] <= -(30'sd3 * c_sf3) + 30'sd768 * c_sf2 + 30'sd393216 * c_sf;
            r_wgt[3] <= c_sf3 - 30'sd65536 * c_sf;
        end
        if (r_cap_en) begin
            r_tap[r_cap_idx] <= $signed(ram_rdata);
        end
        if (i_cmd.mac) begin
            r_prod <= r_wgt[i_cmd.tap] * r_tap[i_cmd.tap];
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.rnd1) begin
            r_u <= 28'(c_t + $signed(29'(DIV3_OFS)));
        end
        if (i_cmd.rnd2) begin
            r_qm <= r_u * RECIP3;
        end
        if (i_cmd.rnd3) begin
            r_wsum <= r_wsum + c_voice;
        end
        if (i_cmd.fin1) begin
            r_p1 <= $signed({1'b0, c_wdry}) * r_x;
        end
        if (i_cmd.fin2) begin
            r_p1n <= r_p1 * $signed({1'b0, c_n});
            r_p2  <= $signed({1'b0, c_w}) * r_wsum;
        end
        if (i_cmd.out_load) begin
            r_out <= c_sat;
        end
    end

    assign o_st.clr_last   = &r_clr;
    assign o_st.last_voice = (r_v == c_nm1);
    assign o_st.div_busy   = div_busy;
    assign o_st.out_free   = !r_ovalid || !i_out_stall;

    assign o_sample_out = r_out;
    assign o_out_valid  = r_ovalid;

endmodule

/* design/multi_voice_chorus_cubic_interp.sv */
// Multi-voice chorus top level: sequencer plus datapath.
// Depends on mvc_pkg, mvc_ctrl and mvc_dp (which holds mvc_ram and mvc_div).
//
// Each accepted word is one signed 24-bit audio sample. The sample goes into
// a 2048-entry circular delay line, then one to eight voices each read the
// line at base_delay + mod_depth * sine(phase) using four-point cubic
// Lagrange interpolation; each voice runs its own sine LFO with a rate spread
// from 0.9 to 1.1 times rate_step. The averaged voices are mixed with the dry
// sample by wet_gain and saturated, giving one output word per input word.
// Timing: after reset the block sweeps the delay line to zero, one entry a
// cycle; input stays stalled meanwhile and configuration writes are taken.
// After that each voice's work is bounded by the single delay line port,
// which delivers the four taps one a cycle, and by the shared multiplier
// chain; after the last voice come the mix and a divide by the voice count.
// A finished word waits in an output register, so the next sample can be
// accepted while it is unread.
// Write configuration only while the block is idle.
module multi_voice_chorus_cubic_interp
    import mvc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    // Registers are always writable; indexes past the list are dropped.
    assign o_cfg_ready = 1'b1;

    mvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mvc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

endmodule
